>>> sv/rvq_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the rotation vector block.
package rvq_pkg;

    localparam int CORDIC_STAGES = 30;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 31;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    localparam logic [30:0]        THRESHOLD_RESET = 31'd268;
    localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30      = 35'sd6746518852;
    localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;

    typedef struct packed {
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
    } gyro_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               is_identity;
    } quat_t;

    // Item handed from the front to the back through the queue.
    typedef struct packed {
        gyro_t       gyro;
        logic [31:0] mag;
        logic        is_identity;
    } class_item_t;

    function automatic logic signed [34:0] atan_entry(input int i);
        logic signed [34:0] r;
        r = '0;
        unique case (i)
            0: r = 35'sd843314857;
            1: r = 35'sd497837830;
            2: r = 35'sd263043837;
            3: r = 35'sd133525159;
            4: r = 35'sd67021687;
            5: r = 35'sd33543515;
            6: r = 35'sd16775851;
            7: r = 35'sd8388437;
            8: r = 35'sd4194283;
            9: r = 35'sd2097149;
            default:
            begin
                if (i <= 30)
                    r = 35'sd1 <<< (30 - i);
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/rvq_fifo.sv
// Short queue that decouples the magnitude front end from the trigonometric back end.
module rvq_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rvq_pkg::class_item_t push_item,
    input  logic                 pop,
    output rvq_pkg::class_item_t head,
    output logic                 full,
    output logic                 empty
);

    rvq_pkg::class_item_t            mem_reg [rvq_pkg::QUEUE_DEPTH];
    logic [rvq_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rvq_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rvq_pkg::QUEUE_AW:0]      count_reg, count_next;

    assign full  = (count_reg == (rvq_pkg::QUEUE_AW+1)'(rvq_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> sv/rvq_front.sv
// Front end: squares, sum of squares, pipelined integer square root and threshold test.
module rvq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 gyro_valid,
    output logic                 gyro_stall,
    input  rvq_pkg::gyro_t       gyro,
    input  logic [30:0]          threshold,
    input  logic                 q_full,
    output logic                 q_push,
    output rvq_pkg::class_item_t q_item
);

    localparam int L = rvq_pkg::SQRT_STAGES;

    logic                en;
    logic [31:0]         ax, ay, az;

    logic                a_v_reg;
    rvq_pkg::gyro_t      a_g_reg;
    logic [63:0]         a_sqx_reg, a_sqy_reg, a_sqz_reg;

    logic                s_v_reg    [L+1];
    rvq_pkg::gyro_t      s_g_reg    [L+1];
    logic [63:0]         s_rem_reg  [L+1];
    logic [31:0]         s_root_reg [L+1];

    // The whole front pipeline holds only when its last item cannot enter the queue.
    assign en         = !(s_v_reg[L] && q_full);
    assign gyro_stall = !en;

    assign ax = gyro.gyro_x[31] ? (32'd0 - 32'(gyro.gyro_x)) : 32'(gyro.gyro_x);
    assign ay = gyro.gyro_y[31] ? (32'd0 - 32'(gyro.gyro_y)) : 32'(gyro.gyro_y);
    assign az = gyro.gyro_z[31] ? (32'd0 - 32'(gyro.gyro_z)) : 32'(gyro.gyro_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            s_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg    <= gyro_valid;
            s_v_reg[0] <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_g_reg       <= gyro;
            a_sqx_reg     <= ax * ax;
            a_sqy_reg     <= ay * ay;
            a_sqz_reg     <= az * az;
            s_g_reg[0]    <= a_g_reg;
            s_rem_reg[0]  <= a_sqx_reg + a_sqy_reg + a_sqz_reg;
            s_root_reg[0] <= '0;
        end
    end

    // One root bit per stage, most significant first; the remainder holds num - root^2.
    for (genvar i = 1; i <= L; i++)
    begin : g_sqrt
        localparam int B = L - i;
        logic [65:0] trial;
        logic        take;

        assign trial = ({34'd0, s_root_reg[i-1]} << (B + 1)) | (66'd1 << (2 * B));
        assign take  = ({2'b00, s_rem_reg[i-1]} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_v_reg[i] <= 1'b0;
            else if (en)
                s_v_reg[i] <= s_v_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_g_reg[i] <= s_g_reg[i-1];
                if (take)
                begin
                    s_rem_reg[i]  <= s_rem_reg[i-1] - trial[63:0];
                    s_root_reg[i] <= s_root_reg[i-1] | (32'd1 << B);
                end
                else
                begin
                    s_rem_reg[i]  <= s_rem_reg[i-1];
                    s_root_reg[i] <= s_root_reg[i-1];
                end
            end
        end
    end

    assign q_push             = s_v_reg[L] && !q_full;
    assign q_item.gyro        = s_g_reg[L];
    assign q_item.mag         = s_root_reg[L];
    assign q_item.is_identity = (s_root_reg[L] <= {1'b0, threshold});

endmodule

>>> sv/rvq_back.sv
// Back end: half-angle folding, CORDIC sine and cosine, scaling and division by the magnitude.
module rvq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  rvq_pkg::class_item_t q_head,
    output logic                 q_pop,
    output logic                 quat_valid,
    input  logic                 quat_stall,
    output rvq_pkg::quat_t       quat
);

    localparam int C = rvq_pkg::CORDIC_STAGES;
    localparam int D = rvq_pkg::DIV_STAGES;

    logic en;

    logic signed [34:0] ang0, ang1, ang2;
    logic               fold_neg;

    logic               c_v_reg   [C+1];
    logic signed [33:0] c_x_reg   [C+1];
    logic signed [33:0] c_y_reg   [C+1];
    logic signed [34:0] c_z_reg   [C+1];
    logic               c_neg_reg [C+1];
    rvq_pkg::gyro_t     c_g_reg   [C+1];
    logic [31:0]        c_mag_reg [C+1];
    logic               c_id_reg  [C+1];

    logic signed [33:0] cos_raw;
    logic               k_v_reg;
    logic signed [31:0] k_w_reg, k_s_reg;
    rvq_pkg::gyro_t     k_g_reg;
    logic [31:0]        k_mag_reg;
    logic               k_id_reg;

    logic               m_v_reg;
    logic signed [63:0] m_px_reg, m_py_reg, m_pz_reg;
    logic signed [31:0] m_w_reg;
    logic [31:0]        m_mag_reg;
    logic               m_id_reg;

    logic               d_v_reg   [D+1];
    logic [63:0]        d_rx_reg  [D+1];
    logic [63:0]        d_ry_reg  [D+1];
    logic [63:0]        d_rz_reg  [D+1];
    logic [30:0]        d_qx_reg  [D+1];
    logic [30:0]        d_qy_reg  [D+1];
    logic [30:0]        d_qz_reg  [D+1];
    logic [2:0]         d_sg_reg  [D+1];
    logic signed [31:0] d_w_reg   [D+1];
    logic [31:0]        d_mag_reg [D+1];
    logic               d_id_reg  [D+1];

    logic               o_v_reg;
    rvq_pkg::quat_t     o_reg;

    assign en         = !(o_v_reg && quat_stall);
    assign q_pop      = en && !q_empty;
    assign quat_valid = o_v_reg;
    assign quat       = o_reg;

    // Half angle equals twice the magnitude code; bring it into [-pi/2, pi/2].
    always_comb
    begin
        ang0     = $signed({2'b00, q_head.mag, 1'b0});
        ang1     = (ang0 > rvq_pkg::PI_Q30) ? (ang0 - rvq_pkg::TWO_PI_Q30) : ang0;
        ang2     = ang1;
        fold_neg = 1'b0;
        priority if (ang1 > rvq_pkg::HALF_PI_Q30)
        begin
            ang2     = rvq_pkg::PI_Q30 - ang1;
            fold_neg = 1'b1;
        end
        else if (ang1 < -rvq_pkg::HALF_PI_Q30)
        begin
            ang2     = -rvq_pkg::PI_Q30 - ang1;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg[0] <= 1'b0;
        else if (en)
            c_v_reg[0] <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_x_reg[0]   <= rvq_pkg::CORDIC_INV_GAIN;
            c_y_reg[0]   <= '0;
            c_z_reg[0]   <= ang2;
            c_neg_reg[0] <= fold_neg;
            c_g_reg[0]   <= q_head.gyro;
            c_mag_reg[0] <= q_head.mag;
            c_id_reg[0]  <= q_head.is_identity;
        end
    end

    for (genvar i = 0; i < C; i++)
    begin : g_cordic
        localparam logic signed [34:0] ATAN = rvq_pkg::atan_entry(i);
        logic signed [33:0] dx, dy;

        assign dx = c_y_reg[i] >>> i;
        assign dy = c_x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_v_reg[i+1] <= 1'b0;
            else if (en)
                c_v_reg[i+1] <= c_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!c_z_reg[i][34])
                begin
                    c_x_reg[i+1] <= c_x_reg[i] - dx;
                    c_y_reg[i+1] <= c_y_reg[i] + dy;
                    c_z_reg[i+1] <= c_z_reg[i] - ATAN;
                end
                else
                begin
                    c_x_reg[i+1] <= c_x_reg[i] + dx;
                    c_y_reg[i+1] <= c_y_reg[i] - dy;
                    c_z_reg[i+1] <= c_z_reg[i] + ATAN;
                end
                c_neg_reg[i+1] <= c_neg_reg[i];
                c_g_reg[i+1]   <= c_g_reg[i];
                c_mag_reg[i+1] <= c_mag_reg[i];
                c_id_reg[i+1]  <= c_id_reg[i];
            end
        end
    end

    assign cos_raw = c_neg_reg[C] ? -c_x_reg[C] : c_x_reg[C];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_v_reg    <= 1'b0;
            m_v_reg    <= 1'b0;
            d_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            k_v_reg    <= c_v_reg[C];
            m_v_reg    <= k_v_reg;
            d_v_reg[0] <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cos_raw > 34'(rvq_pkg::ONE_Q30))
                k_w_reg <= rvq_pkg::ONE_Q30;
            else if (cos_raw < -34'(rvq_pkg::ONE_Q30))
                k_w_reg <= -rvq_pkg::ONE_Q30;
            else
                k_w_reg <= cos_raw[31:0];

            if (c_y_reg[C] > 34'(rvq_pkg::ONE_Q30))
                k_s_reg <= rvq_pkg::ONE_Q30;
            else if (c_y_reg[C] < -34'(rvq_pkg::ONE_Q30))
                k_s_reg <= -rvq_pkg::ONE_Q30;
            else
                k_s_reg <= c_y_reg[C][31:0];

            k_g_reg   <= c_g_reg[C];
            k_mag_reg <= c_mag_reg[C];
            k_id_reg  <= c_id_reg[C];

            m_px_reg  <= k_g_reg.gyro_x * k_s_reg;
            m_py_reg  <= k_g_reg.gyro_y * k_s_reg;
            m_pz_reg  <= k_g_reg.gyro_z * k_s_reg;
            m_w_reg   <= k_w_reg;
            m_mag_reg <= k_mag_reg;
            m_id_reg  <= k_id_reg;

            d_rx_reg[0]  <= m_px_reg[63] ? (64'd0 - 64'(m_px_reg)) : 64'(m_px_reg);
            d_ry_reg[0]  <= m_py_reg[63] ? (64'd0 - 64'(m_py_reg)) : 64'(m_py_reg);
            d_rz_reg[0]  <= m_pz_reg[63] ? (64'd0 - 64'(m_pz_reg)) : 64'(m_pz_reg);
            d_qx_reg[0]  <= '0;
            d_qy_reg[0]  <= '0;
            d_qz_reg[0]  <= '0;
            d_sg_reg[0]  <= {m_px_reg[63], m_py_reg[63], m_pz_reg[63]};
            d_w_reg[0]   <= m_w_reg;
            d_mag_reg[0] <= m_mag_reg;
            d_id_reg[0]  <= m_id_reg;
        end
    end

    // Restoring division of |component * sin| by the magnitude, one quotient bit per stage.
    // Identity items pass through with whatever quotient results and are overridden at the end.
    for (genvar i = 1; i <= D; i++)
    begin : g_div
        localparam int B = D - i;
        logic [63:0] dv;

        assign dv = {32'd0, d_mag_reg[i-1]} << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v_reg[i] <= 1'b0;
            else if (en)
                d_v_reg[i] <= d_v_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (d_rx_reg[i-1] >= dv)
                begin
                    d_rx_reg[i] <= d_rx_reg[i-1] - dv;
                    d_qx_reg[i] <= d_qx_reg[i-1] | (31'd1 << B);
                end
                else
                begin
                    d_rx_reg[i] <= d_rx_reg[i-1];
                    d_qx_reg[i] <= d_qx_reg[i-1];
                end
                if (d_ry_reg[i-1] >= dv)
                begin
                    d_ry_reg[i] <= d_ry_reg[i-1] - dv;
                    d_qy_reg[i] <= d_qy_reg[i-1] | (31'd1 << B);
                end
                else
                begin
                    d_ry_reg[i] <= d_ry_reg[i-1];
                    d_qy_reg[i] <= d_qy_reg[i-1];
                end
                if (d_rz_reg[i-1] >= dv)
                begin
                    d_rz_reg[i] <= d_rz_reg[i-1] - dv;
                    d_qz_reg[i] <= d_qz_reg[i-1] | (31'd1 << B);
                end
                else
                begin
                    d_rz_reg[i] <= d_rz_reg[i-1];
                    d_qz_reg[i] <= d_qz_reg[i-1];
                end
                d_sg_reg[i]  <= d_sg_reg[i-1];
                d_w_reg[i]   <= d_w_reg[i-1];
                d_mag_reg[i] <= d_mag_reg[i-1];
                d_id_reg[i]  <= d_id_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= d_v_reg[D];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_id_reg[D])
            begin
                o_reg.quat_w <= rvq_pkg::ONE_Q30;
                o_reg.quat_x <= '0;
                o_reg.quat_y <= '0;
                o_reg.quat_z <= '0;
            end
            else
            begin
                o_reg.quat_w <= d_w_reg[D];
                o_reg.quat_x <= d_sg_reg[D][2] ? -$signed({1'b0, d_qx_reg[D]})
                                               : $signed({1'b0, d_qx_reg[D]});
                o_reg.quat_y <= d_sg_reg[D][1] ? -$signed({1'b0, d_qy_reg[D]})
                                               : $signed({1'b0, d_qy_reg[D]});
                o_reg.quat_z <= d_sg_reg[D][0] ? -$signed({1'b0, d_qz_reg[D]})
                                               : $signed({1'b0, d_qz_reg[D]});
            end
            o_reg.is_identity <= d_id_reg[D];
        end
    end

endmodule

>>> sv/rotation_vector_to_quaternion_top.sv
// Top level of the rotation vector to quaternion block.
//
// Input channel gyro_valid / gyro_stall / gyro carries one rotation increment
// (x, y, z in signed Q3.28) per item; an item is taken at a clock edge with
// gyro_valid high and gyro_stall low. Output channel quat_valid / quat_stall /
// quat returns one unit quaternion in signed Q1.30 per input item, in order,
// with is_identity set when the magnitude is at or below the threshold.
// small_angle_threshold is written when small_angle_threshold_we is high;
// change it only while no item is in flight.
// One item is accepted every cycle while gyro_stall is low. Items pass through
// the front end (squares, sum, one square root bit per stage), the queue, and
// the back end (fold, 30 CORDIC stages, clamp, multiply, absolute value,
// 31 divider stages, output register).
// When the receiver stalls, the back end holds; the four-entry queue keeps
// the front end running until it fills, and then gyro_stall rises.
// Reset empties both pipelines and the queue and sets the threshold to 268.
module rotation_vector_to_quaternion_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           gyro_valid,
    output logic           gyro_stall,
    input  rvq_pkg::gyro_t gyro,
    output logic           quat_valid,
    input  logic           quat_stall,
    output rvq_pkg::quat_t quat,
    input  logic           small_angle_threshold_we,
    input  logic [30:0]    small_angle_threshold
);

    logic [30:0]          threshold_reg;
    logic                 q_push, q_pop, q_full, q_empty;
    rvq_pkg::class_item_t q_item, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= rvq_pkg::THRESHOLD_RESET;
        else if (small_angle_threshold_we)
            threshold_reg <= small_angle_threshold;
    end

    rvq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .gyro_valid (gyro_valid),
        .gyro_stall (gyro_stall),
        .gyro       (gyro),
        .threshold  (threshold_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    rvq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rvq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat       (quat)
    );

endmodule

>>> dv/tb_rotation_vector_to_quaternion_top.sv
// Self-checking testbench for the rotation vector to quaternion block.
module tb_rotation_vector_to_quaternion_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 110;
    localparam int WATCHDOG    = 20000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_ITEMS   = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 gyro_valid;
    logic                 gyro_stall;
    rvq_pkg::gyro_t       gyro;
    logic                 quat_valid;
    logic                 quat_stall;
    rvq_pkg::quat_t       quat;
    logic                 small_angle_threshold_we;
    logic [30:0]          small_angle_threshold;

    rotation_vector_to_quaternion_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .gyro_valid(gyro_valid),
        .gyro_stall(gyro_stall),
        .gyro(gyro),
        .quat_valid(quat_valid),
        .quat_stall(quat_stall),
        .quat(quat),
        .small_angle_threshold_we(small_angle_threshold_we),
        .small_angle_threshold(small_angle_threshold)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    rvq_pkg::quat_t expected_quats[$];
    logic [30:0]    model_threshold;
    int             mismatches;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_cycles;
    int             quiet_cycles;
    int             quats_seen;
    int             identity_seen;

    // Floor square root of an unsigned 64-bit value, one result bit at a time.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] num);
        logic [63:0] res;
        logic [63:0] bit_val;
        res = '0;
        bit_val = 64'd1 << 62;
        while (bit_val > num)
            bit_val = bit_val >> 2;
        while (bit_val != 0)
        begin
            if (num >= res + bit_val)
            begin
                num = num - (res + bit_val);
                res = (res >> 1) + bit_val;
            end
            else
                res = res >> 1;
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_q30(input int i);
        longint head[10];
        head = '{843314857, 497837830, 263043837, 133525159, 67021687,
                 33543515, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return head[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    function automatic rvq_pkg::quat_t predict_quat(input rvq_pkg::gyro_t g);
        rvq_pkg::quat_t q;
        longint      comp[3];
        logic [63:0] sumsq;
        logic [63:0] mag;
        longint      ang;
        longint      cx;
        longint      cy;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        bit          neg_cos;
        comp[0] = g.gyro_x;
        comp[1] = g.gyro_y;
        comp[2] = g.gyro_z;
        sumsq = '0;
        for (int k = 0; k < 3; k++)
            sumsq = sumsq + 64'(comp[k] * comp[k]);
        mag = floor_sqrt(sumsq);
        if (mag <= {33'd0, model_threshold})
        begin
            q = '{quat_w: 32'sd1073741824, quat_x: '0, quat_y: '0, quat_z: '0,
                  is_identity: 1'b1};
            return q;
        end
        ang = longint'(mag) * 2;
        neg_cos = 1'b0;
        if (ang > 64'sd3373259426)
            ang = ang - 64'sd6746518852;
        if (ang > 64'sd1686629713)
        begin
            ang = 64'sd3373259426 - ang;
            neg_cos = 1'b1;
        end
        else if (ang < -64'sd1686629713)
        begin
            ang = -64'sd3373259426 - ang;
            neg_cos = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        z = ang;
        for (int i = 0; i < rvq_pkg::CORDIC_STAGES; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - atan_q30(i);
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + atan_q30(i);
            end
        end
        c = clamp_unit(neg_cos ? -cx : cx);
        s = clamp_unit(cy);
        q.quat_w = c[31:0];
        q.quat_x = 32'((comp[0] * s) / longint'(mag));
        q.quat_y = 32'((comp[1] * s) / longint'(mag));
        q.quat_z = 32'((comp[2] * s) / longint'(mag));
        q.is_identity = 1'b0;
        return q;
    endfunction

    // Valid stays up after an accept so that the next item can follow at once.
    task automatic send_gyro(input rvq_pkg::gyro_t g);
        while ($urandom_range(99) < send_idle_pct)
        begin
            gyro_valid <= 1'b0;
            @(posedge clk);
        end
        gyro_valid <= 1'b1;
        gyro <= g;
        @(posedge clk);
        while (gyro_stall)
            @(posedge clk);
        expected_quats.push_back(predict_quat(g));
    endtask

    task automatic drain_quats();
        gyro_valid <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        small_angle_threshold_we <= 1'b1;
        small_angle_threshold <= value;
        @(posedge clk);
        small_angle_threshold_we <= 1'b0;
        model_threshold = value;
    endtask

    function automatic logic signed [31:0] rand_component(input int scale);
        logic signed [31:0] v;
        v = $urandom;
        case (scale)
            0: v = v >>> 20;
            1: v = v >>> 8;
            2: v = v >>> 2;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        rvq_pkg::gyro_t g;
        int    scale;
        for (int n = 0; n < count; n++)
        begin
            scale = $urandom_range(3);
            g.gyro_x = rand_component(scale);
            g.gyro_y = rand_component(scale);
            g.gyro_z = rand_component(scale);
            if ($urandom_range(9) == 0)
                g.gyro_y = 0;
            send_gyro(g);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off that fills the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            quat_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            quat_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && quat_valid && !quat_stall)
        begin
            quats_seen <= quats_seen + 1;
            if (quat.is_identity)
                identity_seen <= identity_seen + 1;
            if (expected_quats.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected quaternion item: %p", quat);
            end
            else if (quat !== expected_quats[0])
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Quaternion mismatch: expected %p, got %p",
                             expected_quats[0], quat);
                void'(expected_quats.pop_front());
            end
            else
                void'(expected_quats.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((gyro_valid && !gyro_stall) || (quat_valid && !quat_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Watchdog expired with %0d items outstanding",
                     expected_quats.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Directed rows; rows with check set carry an expected result read off directly.
    typedef struct {
        rvq_pkg::gyro_t g;
        bit             check;
        rvq_pkg::quat_t q;
    } gyro_row_t;

    gyro_row_t rows[$];

    initial
    begin
        rvq_pkg::quat_t ident;
        rvq_pkg::gyro_t g;
        mismatches = 0;
        quats_seen = 0;
        identity_seen = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        gyro_valid = 1'b0;
        gyro = '0;
        small_angle_threshold_we = 1'b0;
        small_angle_threshold = '0;
        model_threshold = rvq_pkg::THRESHOLD_RESET;
        ident = '{quat_w: 32'sd1073741824, quat_x: '0, quat_y: '0, quat_z: '0,
                  is_identity: 1'b1};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, ident});
        rows.push_back('{'{32'sd268, 32'sd0, 32'sd0}, 1'b1, ident});
        rows.push_back('{'{32'sd0, -32'sd268, 32'sd0}, 1'b1, ident});
        rows.push_back('{'{32'sd0, 32'sd0, 32'sd269}, 1'b0, ident});
        rows.push_back('{'{32'sh7fffffff, 32'sd0, 32'sd0}, 1'b0, ident});
        rows.push_back('{'{32'sh80000000, 32'sd0, 32'sd0}, 1'b0, ident});
        rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, ident});
        rows.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, ident});
        rows.push_back('{'{32'sh80000000, 32'sh7fffffff, 32'sh80000000}, 1'b0, ident});
        // Half angle just around pi/2, pi and beyond, where folding kicks in.
        rows.push_back('{'{32'sd843314856, 32'sd0, 32'sd0}, 1'b0, ident});
        rows.push_back('{'{32'sd843314857, 32'sd0, 32'sd0}, 1'b0, ident});
        rows.push_back('{'{32'sd1686629713, 32'sd0, 32'sd0}, 1'b0, ident});
        rows.push_back('{'{-32'sd1686629714, 32'sd0, 32'sd0}, 1'b0, ident});
        rows.push_back('{'{32'sd268435456, 32'sd268435456, -32'sd268435456}, 1'b0, ident});
        rows.push_back('{'{-32'sd1, 32'sd1, -32'sd1}, 1'b1, ident});
        rows.push_back('{'{32'sh55555555, 32'shAAAAAAAA, 32'sh12345678}, 1'b0, ident});
        foreach (rows[i])
        begin
            send_gyro(rows[i].g);
            if (rows[i].check)
                expected_quats[expected_quats.size() - 1] = rows[i].q;
        end
        drain_quats();

        // Threshold extremes: zero, then the largest value.
        write_threshold('0);
        g = '{32'sd1, 32'sd0, 32'sd0};
        send_gyro(g);
        send_random(60);
        drain_quats();
        write_threshold(31'h7fffffff);
        send_random(40);
        drain_quats();
        write_threshold(31'd200000);
        send_idle_pct = 19;
        recv_idle_pct = 46;
        send_random(RANDOM_ITEMS / 3);

        // Long receiver hold-off while the sender keeps offering.
        hold_cycles = 300;
        send_idle_pct = 0;
        send_random(HOLD_ITEMS);
        drain_quats();

        write_threshold(rvq_pkg::THRESHOLD_RESET);
        send_idle_pct = 46;
        recv_idle_pct = 19;
        send_random(RANDOM_ITEMS / 3);
        drain_quats();
        write_threshold(31'd5000000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_ITEMS / 3);
        drain_quats();

        $display("Checked %0d quaternion items, %0d of them identity, over five threshold settings.",
                 quats_seen, identity_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
